### rtl/core/usan_pkg.sv
// Package for the UTF-8 stream sanitizer: code constants, controller states and
// the command and status records between the controller and the datapath.
// Depends on nothing; the datapath, the controller and the top level import it.
package usan_pkg;

	localparam int unsigned MAX_UNITS = 4;
	localparam int unsigned UNIT_CNT_W = 3;
	localparam int unsigned UNIT_IDX_W = 2;
	localparam int unsigned SUB_IDX_W = 2;
	localparam int unsigned CODE_W = 21;

	localparam logic [7:0] REPL_BYTE0 = 8'hEF;
	localparam logic [7:0] REPL_BYTE1 = 8'hBF;
	localparam logic [7:0] REPL_BYTE2 = 8'hBD;

	localparam logic [SUB_IDX_W-1:0] SUB_FIRST = 2'd0;
	localparam logic [SUB_IDX_W-1:0] SUB_MID = 2'd1;
	localparam logic [SUB_IDX_W-1:0] SUB_LAST = 2'd2;

	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_TWO = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FOUR = 3'd4;

	localparam logic [CODE_W-1:0] CODE_MIN_TWO = 21'h000080;
	localparam logic [CODE_W-1:0] CODE_MIN_THREE = 21'h000800;
	localparam logic [CODE_W-1:0] CODE_MIN_FOUR = 21'h010000;
	localparam logic [CODE_W-1:0] CODE_MAX = 21'h10FFFF;
	localparam logic [CODE_W-1:0] SURR_LOW = 21'h00D800;
	localparam logic [CODE_W-1:0] SURR_HIGH = 21'h00DFFF;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} ctl_state_t;

	typedef struct packed {
		logic                  take_ok;
		logic                  emit;
		logic                  last_byte;
		logic [UNIT_IDX_W-1:0] unit_idx;
		logic [SUB_IDX_W-1:0]  sub_idx;
	} cmd_t;

	typedef struct packed {
		logic                  loaded;
		logic [UNIT_CNT_W-1:0] plan_units;
		logic [UNIT_CNT_W-1:0] units;
		logic                  cur_rep;
		logic                  out_free;
	} sts_t;

	// One byte of the replacement character U+FFFD.
	function automatic logic [7:0] repl_byte(input logic [SUB_IDX_W-1:0] sub);
		logic [7:0] r;
		unique case (sub)
			SUB_FIRST: r = REPL_BYTE0;
			SUB_MID:   r = REPL_BYTE1;
			SUB_LAST:  r = REPL_BYTE2;
			default:   r = REPL_BYTE2;
		endcase
		return r;
	endfunction

endpackage

### rtl/core/usan_in_if.sv
// Input channel of the UTF-8 stream sanitizer: one raw word and its end flag.
// Depends on nothing.
interface usan_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       text_end;

	modport source(output valid, output in_byte, output text_end, input ready);
	modport sink(input valid, input in_byte, input text_end, output ready);
endinterface

### rtl/core/usan_out_if.sv
// Output channel of the UTF-8 stream sanitizer: one sanitized word and its flags.
// Depends on nothing.
interface usan_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       text_done;
	logic       text_valid;

	modport source(output valid, output out_byte, output run_last, output text_done,
		output text_valid, input ready);
	modport sink(input valid, input out_byte, input run_last, input text_done,
		input text_valid, output ready);
endinterface

### rtl/core/usan_datapath.sv
// Datapath of the UTF-8 stream sanitizer: decoder state, emission plan and
// output register. Depends on usan_pkg, usan_in_if and usan_out_if.
module usan_datapath (
	input  logic          clk,
	input  logic          arst_n,
	usan_in_if.sink       raw,
	usan_out_if.source    clean,
	input  usan_pkg::cmd_t cmd,
	output usan_pkg::sts_t sts
);
	import usan_pkg::*;

	logic [7:0]            held_q [3];
	logic [1:0]            held_cnt_q;
	logic [2:0]            seq_len_q;
	logic [CODE_W-1:0]     acc_q;
	logic                  repl_seen_q;

	logic [MAX_UNITS-1:0]  unit_rep_q;
	logic [7:0]            unit_byte_q [MAX_UNITS];
	logic [UNIT_CNT_W-1:0] units_q;
	logic                  text_ok_q;
	logic                  text_end_q;

	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	logic                  run_last_q;
	logic                  text_done_q;
	logic                  text_valid_q;

	logic [7:0]            b;
	logic                  load;
	logic                  is_cont, is_ascii, is_l2, is_l3, is_l4, is_lead, is_bad;
	logic                  active, take_cont, complete, code_ok, pass_all;
	logic [CODE_W-1:0]     acc_ext, code_min;
	logic [UNIT_CNT_W-1:0] h_ext, rep_n, units_n;
	logic                  pass_b, any_rep;
	logic [MAX_UNITS-1:0]  unit_rep_n;
	logic [7:0]            unit_byte_n [MAX_UNITS];
	logic [7:0]            emit_byte;

	assign b = raw.in_byte;
	assign load = raw.valid & cmd.take_ok;
	assign raw.ready = cmd.take_ok;

	assign is_cont = (b[7:6] == 2'b10);
	assign is_ascii = ~b[7];
	assign is_l2 = (b[7:5] == 3'b110);
	assign is_l3 = (b[7:4] == 4'b1110);
	assign is_l4 = (b[7:3] == 5'b11110);
	assign is_lead = is_l2 | is_l3 | is_l4;
	assign is_bad = ~is_ascii & ~is_lead;

	assign active = (held_cnt_q != 2'd0);
	assign take_cont = active & is_cont;
	assign h_ext = {1'b0, held_cnt_q};
	assign acc_ext = {acc_q[CODE_W-7:0], b[5:0]};
	assign complete = ((h_ext + 3'd1) >= seq_len_q);

	always_comb begin
		unique case (seq_len_q)
			LEN_TWO:   code_min = CODE_MIN_TWO;
			LEN_THREE: code_min = CODE_MIN_THREE;
			default:   code_min = CODE_MIN_FOUR;
		endcase
	end

	assign code_ok = (acc_ext >= code_min) && (acc_ext <= CODE_MAX) &&
		!((acc_ext >= SURR_LOW) && (acc_ext <= SURR_HIGH));
	assign pass_all = take_cont & complete & code_ok;

	// The plan is a run of replacements, optionally followed by the new byte,
	// or, for a good sequence, the held bytes and the new byte passed through.
	always_comb begin
		if (take_cont) begin
			pass_b = 1'b0;
			if (complete) begin
				rep_n = code_ok ? 3'd0 : (h_ext + 3'd1);
			end else begin
				rep_n = raw.text_end ? (h_ext + 3'd1) : 3'd0;
			end
		end else begin
			pass_b = is_ascii;
			rep_n = h_ext + {2'b00, is_bad} + {2'b00, is_lead & raw.text_end};
		end
	end

	assign units_n = pass_all ? (h_ext + 3'd1) : (rep_n + {2'b00, pass_b});
	assign any_rep = ~pass_all & (rep_n != 3'd0);

	always_comb begin
		for (int i = 0; i < MAX_UNITS; i++) begin
			unit_rep_n[i] = ~pass_all && (rep_n > UNIT_CNT_W'(i));
		end
		unit_byte_n[0] = (pass_all && held_cnt_q > 2'd0) ? held_q[0] : b;
		unit_byte_n[1] = (pass_all && held_cnt_q > 2'd1) ? held_q[1] : b;
		unit_byte_n[2] = (pass_all && held_cnt_q > 2'd2) ? held_q[2] : b;
		unit_byte_n[3] = b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
			seq_len_q <= LEN_NONE;
			acc_q <= '0;
			repl_seen_q <= 1'b0;
			units_q <= '0;
			text_ok_q <= 1'b0;
			text_end_q <= 1'b0;
		end else if (load) begin
			units_q <= units_n;
			text_ok_q <= ~(repl_seen_q | any_rep);
			text_end_q <= raw.text_end;
			if (raw.text_end) begin
				held_cnt_q <= 2'd0;
				seq_len_q <= LEN_NONE;
				acc_q <= '0;
				repl_seen_q <= 1'b0;
			end else begin
				repl_seen_q <= repl_seen_q | any_rep;
				if (take_cont && !complete) begin
					held_cnt_q <= held_cnt_q + 2'd1;
					acc_q <= acc_ext;
				end else if (!take_cont && is_lead) begin
					held_cnt_q <= 2'd1;
					priority if (is_l2) begin
						seq_len_q <= LEN_TWO;
						acc_q <= {16'd0, b[4:0]};
					end else if (is_l3) begin
						seq_len_q <= LEN_THREE;
						acc_q <= {17'd0, b[3:0]};
					end else begin
						seq_len_q <= LEN_FOUR;
						acc_q <= {18'd0, b[2:0]};
					end
				end else begin
					held_cnt_q <= 2'd0;
					seq_len_q <= LEN_NONE;
					acc_q <= '0;
				end
			end
		end
	end

	// Held words and the plan contents carry no reset.
	always_ff @(posedge clk) begin
		if (load) begin
			unit_rep_q <= unit_rep_n;
			for (int i = 0; i < MAX_UNITS; i++) begin
				unit_byte_q[i] <= unit_byte_n[i];
			end
			if (take_cont && !complete) begin
				for (int i = 0; i < 3; i++) begin
					if (held_cnt_q == 2'(i)) begin
						held_q[i] <= b;
					end
				end
			end else if (!take_cont && is_lead) begin
				held_q[0] <= b;
			end
		end
	end

	assign emit_byte = unit_rep_q[cmd.unit_idx] ? repl_byte(cmd.sub_idx)
		: unit_byte_q[cmd.unit_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (clean.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_byte_q <= emit_byte;
			run_last_q <= cmd.last_byte;
			text_done_q <= cmd.last_byte & text_end_q;
			text_valid_q <= cmd.last_byte & text_end_q & text_ok_q;
		end
	end

	assign clean.valid = out_valid_q;
	assign clean.out_byte = out_byte_q;
	assign clean.run_last = run_last_q;
	assign clean.text_done = text_done_q;
	assign clean.text_valid = text_valid_q;

	assign sts.loaded = load;
	assign sts.plan_units = units_n;
	assign sts.units = units_q;
	assign sts.cur_rep = unit_rep_q[cmd.unit_idx];
	assign sts.out_free = ~out_valid_q | clean.ready;

	a_held_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		held_cnt_q != 2'd0 |-> h_ext < seq_len_q)
		else $error("held count reached the sequence length");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		load && raw.text_end |=> held_cnt_q == 2'd0 && !repl_seen_q)
		else $error("decoder state not cleared after the final word");

	a_plan_fits: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> units_n <= UNIT_CNT_W'(MAX_UNITS))
		else $error("emission plan longer than the unit buffer");

endmodule

### rtl/core/usan_ctrl.sv
// Controller of the UTF-8 stream sanitizer: sequences the planned units and
// the words of each replacement. Depends on usan_pkg.
module usan_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  usan_pkg::sts_t sts,
	output usan_pkg::cmd_t cmd
);
	import usan_pkg::*;

	ctl_state_t            state_q;
	logic [UNIT_IDX_W-1:0] unit_idx_q;
	logic [SUB_IDX_W-1:0]  sub_idx_q;
	logic                  unit_done, last_unit, emit;

	assign unit_done = ~sts.cur_rep | (sub_idx_q == SUB_LAST);
	assign last_unit = ({1'b0, unit_idx_q} == (sts.units - 3'd1));
	assign emit = (state_q == ST_EMIT) & sts.out_free;

	assign cmd.take_ok = (state_q == ST_IDLE);
	assign cmd.emit = emit;
	assign cmd.last_byte = last_unit & unit_done;
	assign cmd.unit_idx = unit_idx_q;
	assign cmd.sub_idx = sub_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			unit_idx_q <= '0;
			sub_idx_q <= SUB_FIRST;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (sts.loaded && sts.plan_units != 3'd0) begin
						state_q <= ST_EMIT;
						unit_idx_q <= '0;
						sub_idx_q <= SUB_FIRST;
					end
				end
				ST_EMIT: begin
					if (emit) begin
						if (last_unit && unit_done) begin
							state_q <= ST_IDLE;
						end else if (unit_done) begin
							unit_idx_q <= unit_idx_q + 2'd1;
							sub_idx_q <= SUB_FIRST;
						end else begin
							sub_idx_q <= sub_idx_q + 2'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_idx_in_plan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> {1'b0, unit_idx_q} < sts.units)
		else $error("unit index beyond the plan");

	a_pass_single: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && !sts.cur_rep |-> sub_idx_q == SUB_FIRST)
		else $error("passed word sequenced as a replacement");

	a_sub_range: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !(last_unit && unit_done) |=> state_q == ST_EMIT)
		else $error("left emission before the last word");

endmodule

### rtl/core/utf8_stream_sanitizer_core.sv
// Top level of the UTF-8 stream sanitizer: controller plus datapath.
// Depends on usan_pkg, usan_in_if, usan_out_if, usan_datapath and usan_ctrl.
//
//   channel | role   | word payload
//   --------+--------+-------------------------------------------------
//   raw     | sink   | in_byte[7:0], text_end
//   clean   | source | out_byte[7:0], run_last, text_done, text_valid
//
// An input word is taken while the controller is idle; it then produces its
// result words at one word per cycle while the output side takes them, n
// result words in all (n is 0 to 12). The unit sequencer in the controller
// steps through the plan one output word at a time, and takes no new input
// until the last one is loaded. The output register keeps the last result of
// one word while the next input word is accepted. Reset is asynchronous and
// active low and returns the decoder to the empty state with no replacement
// seen. A stall on the output channel holds the sequencer; the input stays
// blocked.
//
// A good multi-byte sequence is held in the datapath until it is complete and
// then passed through in order. A failure turns each held word, and a final
// continuation that makes an invalid code, into EF BF BD; another offending
// word is looked at again as a possible new lead. The final word of a text
// also flushes what is still held and carries the verdict on the whole text.
module utf8_stream_sanitizer_core (
	input  logic       clk,
	input  logic       arst_n,
	usan_in_if.sink    raw,
	usan_out_if.source clean
);
	import usan_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// The controller only sees status; all words stay in the datapath.
	usan_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	usan_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw),
		.clean  (clean),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule
